[hw/rtl/elpd_pkg.sv]
// Package for the escape-coded length prefix decoder.
// Holds the escape limits, the phase encoding and the result layout.
// No dependencies.
package elpd_pkg;

  localparam logic [7:0]  ESC_L1     = 8'd255;
  localparam logic [31:0] ESC_L2     = 32'd65535;
  localparam logic [31:0] ESC_L3     = 32'd16777215;
  localparam logic [31:0] ESC_SUM_12 = 32'd255 + ESC_L2;
  localparam logic [31:0] ESC_SUM_123 = 32'd255 + ESC_L2 + ESC_L3;

  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned OUT_DATA_W = 40;

  // Decoder phase, one-hot.
  typedef enum logic [3:0] {
    PH_FIRST = 4'b0001,
    PH_GRP2  = 4'b0010,
    PH_GRP3  = 4'b0100,
    PH_GRP4  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]  encoded_length;
    logic [SIZE_W-1:0] size_value;
  } result_t;

endpackage

[hw/rtl/escape_length_prefix_decoder_unit.sv]
// Top level of the escape-coded length prefix decoder.
// Byte stream in, decoded sizes out. Depends on elpd_pkg.
//
// A result is registered in the output register, or in the skid slot while output waits.
// One byte per cycle while the skid slot is empty. Decode path: one 32-bit add and compare.
// Reset (rst, synchronous, active high) clears the phase, counters and both output slots.
module escape_length_prefix_decoder_unit
  import elpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] size_value, [35:32] encoded_length, rest zero
);

  // Decoder state.
  phase_t      phase, phase_next;
  logic [2:0]  group_bytes_seen, group_bytes_seen_next;
  logic [31:0] group_accumulator, group_accumulator_next;
  logic [31:0] running_total, running_total_next;
  logic [3:0]  bytes_consumed, bytes_consumed_next;

  // Output register plus a skid slot, so a byte can be taken while a result waits.
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;

  logic    in_fire;
  logic    res_valid;
  result_t res_data;
  logic [2:0]  group_len;
  logic [31:0] acc_shift;
  logic [31:0] total_sum;
  logic [2:0]  seen_inc;
  logic [3:0]  consumed_inc;

  // The skid slot is the only thing that can stop the input.
  assign s_axis_tready = ~skid_valid;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - SIZE_W - LEN_W){1'b0}}, out_data};

  // Decode step for the byte at the input.
  always_comb begin
    case (phase)
      PH_GRP2: group_len = 3'd2;
      PH_GRP3: group_len = 3'd3;
      PH_GRP4: group_len = 3'd4;
      default: group_len = 3'd1;
    endcase

    acc_shift    = {group_accumulator[23:0], s_axis_tdata};
    total_sum    = running_total + acc_shift;
    seen_inc     = group_bytes_seen + 3'd1;
    consumed_inc = bytes_consumed + 4'd1;

    phase_next             = phase;
    group_bytes_seen_next  = group_bytes_seen;
    group_accumulator_next = group_accumulator;
    running_total_next     = running_total;
    bytes_consumed_next    = bytes_consumed;
    res_valid              = 1'b0;
    res_data.size_value    = total_sum;
    res_data.encoded_length = consumed_inc;

    if (in_fire) begin
      if (phase == PH_FIRST) begin
        // A first byte below the escape value is the whole size.
        res_data.size_value     = {24'd0, s_axis_tdata};
        res_data.encoded_length = 4'd1;
        if (s_axis_tdata != ESC_L1) begin
          res_valid = 1'b1;
        end else begin
          phase_next             = PH_GRP2;
          group_bytes_seen_next  = 3'd0;
          group_accumulator_next = 32'd0;
          running_total_next     = {24'd0, s_axis_tdata};
          bytes_consumed_next    = 4'd1;
        end
      end else if (seen_inc != group_len) begin
        // Still inside a big-endian group.
        group_accumulator_next = acc_shift;
        group_bytes_seen_next  = seen_inc;
        bytes_consumed_next    = consumed_inc;
      end else if (phase == PH_GRP2 && total_sum == ESC_SUM_12) begin
        // Total hit the second escape, so a 3-byte group follows.
        phase_next             = PH_GRP3;
        group_bytes_seen_next  = 3'd0;
        group_accumulator_next = 32'd0;
        running_total_next     = total_sum;
        bytes_consumed_next    = consumed_inc;
      end else if (phase == PH_GRP3 && total_sum == ESC_SUM_123) begin
        // Total hit the third escape, so a 4-byte group follows.
        phase_next             = PH_GRP4;
        group_bytes_seen_next  = 3'd0;
        group_accumulator_next = 32'd0;
        running_total_next     = total_sum;
        bytes_consumed_next    = consumed_inc;
      end else begin
        res_valid = 1'b1;
      end

      // Any finished prefix returns the decoder to its starting state.
      if (res_valid) begin
        phase_next             = PH_FIRST;
        group_bytes_seen_next  = 3'd0;
        group_accumulator_next = 32'd0;
        running_total_next     = 32'd0;
        bytes_consumed_next    = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_FIRST;
      group_bytes_seen  <= 3'd0;
      group_accumulator <= 32'd0;
      running_total     <= 32'd0;
      bytes_consumed    <= 4'd0;
    end else begin
      phase             <= phase_next;
      group_bytes_seen  <= group_bytes_seen_next;
      group_accumulator <= group_accumulator_next;
      running_total     <= running_total_next;
      bytes_consumed    <= bytes_consumed_next;
    end
  end

  // Output slots. A new result goes to the output register when it is free or
  // being drained; otherwise it waits in the skid slot, which then stalls the input.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_axis_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (res_valid) begin
        out_data <= res_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (res_valid) begin
        out_data  <= res_data;
        out_valid <= 1'b1;
      end
    end else if (res_valid) begin
      skid_data  <= res_data;
      skid_valid <= 1'b1;
    end
  end

endmodule
